// ----- hdl/assert_macros.svh -----
// Assertion macros for the triangle point predicate block.
// No dependencies; a module that includes this must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tpp_pkg.sv -----
// Shared types and constants for the triangle point predicate pipeline.
// No dependencies; used by tpp_wide_mul and triangle_point_predicates_top.
`default_nettype none

package tpp_pkg;

	// Coordinate width; every internal width below follows from it (valid range 8..32).
	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;        // q - p
	localparam int PROD_W     = 2 * DIFF_W;            // one coordinate product
	localparam int ORIENT_W   = PROD_W + 1;            // difference of two products
	localparam int LEN_W      = PROD_W;                // squared length, never negative
	localparam int SPLIT_W    = DIFF_W;                // low slice of a wide operand
	localparam int PART_W     = 2 * SPLIT_W + 2;       // one partial product
	localparam int TERM_W     = LEN_W + ORIENT_W;      // squared length times orient
	localparam int DET_W      = TERM_W + 2;            // sum of three terms
	localparam int WHOLE_W    = ORIENT_W + 2;          // sum of three orients
	localparam int ABS_SUM_W  = ORIENT_W + 2;          // sum of three absolute orients

	typedef enum logic [1:0] {
		EDGE_AB   = 2'd0,
		EDGE_BC   = 2'd1,
		EDGE_CA   = 2'd2,
		EDGE_NONE = 2'd3
	} edge_code_t;

	typedef enum logic [1:0] {
		ORIENT_ZERO = 2'd0,
		ORIENT_CCW  = 2'd1,
		ORIENT_CW   = 2'd2
	} orient_code_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_a_x;
		logic signed [COORD_BITS-1:0] vertex_a_y;
		logic signed [COORD_BITS-1:0] vertex_b_x;
		logic signed [COORD_BITS-1:0] vertex_b_y;
		logic signed [COORD_BITS-1:0] vertex_c_x;
		logic signed [COORD_BITS-1:0] vertex_c_y;
		logic signed [COORD_BITS-1:0] query_x;
		logic signed [COORD_BITS-1:0] query_y;
	} tpp_req_t;

	typedef struct packed {
		logic       inside_res;
		logic       on_edge;
		logic [1:0] edge_index;
		logic       in_circle;
		logic       degenerate;
		logic [1:0] orientation;
	} tpp_res_t;

	// Load strobes for the two register stages of the split multiplier.
	typedef struct packed {
		logic s4;
		logic s5;
	} tpp_stage_en_t;

endpackage

`default_nettype wire

// ----- hdl/triangle_point_predicates_top.sv -----
// Triangle point predicates, six-stage pipeline: one request in, one result out per clock
// while nothing stalls. Takes a request of three vertices a, b, c and a point p on a
// signed integer grid and reports, exactly: whether p lies in the closed triangle, whether
// p lies on an edge and on which one (ab first, then bc, then ca), whether p lies strictly
// inside the circumcircle (relative to the winding of abc, zero for collinear vertices),
// and the winding of abc. A new request may enter every cycle while nothing stalls. Each
// request passes through the chain subtract, multiply, combine, split multiply (two
// stages) and final sum, each with a register behind it, the first of them loaded at the
// accept edge itself. Backpressure on res_ready travels up a ready chain stage by stage,
// so bubbles collapse and a stall loses or repeats nothing. Depends on tpp_pkg, tpp_wide_mul
// and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module triangle_point_predicates_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire tpp_pkg::tpp_req_t req_data,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output tpp_pkg::tpp_res_t      res_data
);

	localparam int DW = tpp_pkg::DIFF_W;
	localparam int PW = tpp_pkg::PROD_W;
	localparam int OW = tpp_pkg::ORIENT_W;
	localparam int LW = tpp_pkg::LEN_W;
	localparam int TW = tpp_pkg::TERM_W;
	localparam int DT = tpp_pkg::DET_W;
	localparam int WW = tpp_pkg::WHOLE_W;
	localparam int AW = tpp_pkg::ABS_SUM_W;

	// ------------------------------------------------------------------
	// Handshake: a stage takes new data when it is empty or its contents
	// move on in the same cycle.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	tpp_pkg::tpp_stage_en_t mul_en;

	assign rdy6 = !v_s6 || res_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign req_ready = rdy1;
	assign res_valid = v_s6;

	// Hold a stage's valid bit unless the stage takes what sits upstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: translate the vertices so that p sits at the origin.
	// Every later quantity is translation invariant, and with
	// Oij = xi*yj - xj*yi the three sub-areas are O12 (pbc), O20 (apc),
	// O01 (abp), while the whole area of abc is their sum.
	// ------------------------------------------------------------------
	logic signed [DW-1:0] x0_s1, y0_s1, x1_s1, y1_s1, x2_s1, y2_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && req_valid) begin
			x0_s1 <= DW'(req_data.vertex_a_x) - DW'(req_data.query_x);
			y0_s1 <= DW'(req_data.vertex_a_y) - DW'(req_data.query_y);
			x1_s1 <= DW'(req_data.vertex_b_x) - DW'(req_data.query_x);
			y1_s1 <= DW'(req_data.vertex_b_y) - DW'(req_data.query_y);
			x2_s1 <= DW'(req_data.vertex_c_x) - DW'(req_data.query_x);
			y2_s1 <= DW'(req_data.vertex_c_y) - DW'(req_data.query_y);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: twelve narrow products, plus the inclusive bounding box test
	// per edge. p lies in the box of edge uv exactly when the translated
	// coordinates of u and v do not share a strict sign, on both axes.
	// ------------------------------------------------------------------
	logic signed [PW-1:0] xy01_s2, yx01_s2, xy12_s2, yx12_s2, xy20_s2, yx20_s2;
	logic signed [PW-1:0] sqx0_s2, sqy0_s2, sqx1_s2, sqy1_s2, sqx2_s2, sqy2_s2;
	logic [2:0]           box_s2;
	logic [2:0]           box_d;

	function automatic logic spans_zero(input logic signed [DW-1:0] u,
		input logic signed [DW-1:0] v);
		logic u_neg, v_neg, u_pos, v_pos;
		u_neg = u[DW-1];
		v_neg = v[DW-1];
		u_pos = !u_neg && (u != '0);
		v_pos = !v_neg && (v != '0);
		return !((u_neg && v_neg) || (u_pos && v_pos));
	endfunction

	assign box_d[0] = spans_zero(x0_s1, x1_s1) && spans_zero(y0_s1, y1_s1);
	assign box_d[1] = spans_zero(x1_s1, x2_s1) && spans_zero(y1_s1, y2_s1);
	assign box_d[2] = spans_zero(x2_s1, x0_s1) && spans_zero(y2_s1, y0_s1);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			xy01_s2 <= PW'(x0_s1) * PW'(y1_s1);
			yx01_s2 <= PW'(y0_s1) * PW'(x1_s1);
			xy12_s2 <= PW'(x1_s1) * PW'(y2_s1);
			yx12_s2 <= PW'(y1_s1) * PW'(x2_s1);
			xy20_s2 <= PW'(x2_s1) * PW'(y0_s1);
			yx20_s2 <= PW'(y2_s1) * PW'(x0_s1);
			sqx0_s2 <= PW'(x0_s1) * PW'(x0_s1);
			sqy0_s2 <= PW'(y0_s1) * PW'(y0_s1);
			sqx1_s2 <= PW'(x1_s1) * PW'(x1_s1);
			sqy1_s2 <= PW'(y1_s1) * PW'(y1_s1);
			sqx2_s2 <= PW'(x2_s1) * PW'(x2_s1);
			sqy2_s2 <= PW'(y2_s1) * PW'(y2_s1);
			box_s2  <= box_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: orient values and squared lengths.
	// ------------------------------------------------------------------
	logic signed [OW-1:0] o01_s3, o12_s3, o20_s3;
	logic signed [LW-1:0] l0_s3, l1_s3, l2_s3;
	logic [2:0]           box_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			o01_s3 <= OW'(xy01_s2) - OW'(yx01_s2);
			o12_s3 <= OW'(xy12_s2) - OW'(yx12_s2);
			o20_s3 <= OW'(xy20_s2) - OW'(yx20_s2);
			l0_s3  <= sqx0_s2 + sqy0_s2;
			l1_s3  <= sqx1_s2 + sqy1_s2;
			l2_s3  <= sqx2_s2 + sqy2_s2;
			box_s3 <= box_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: whole area, sum of absolute sub-areas, edge pick. The
	// incircle determinant, expanded along the squared-length column, is
	// l0*O12 + l1*O20 + l2*O01; its three terms start in the split
	// multipliers here and finish at stage 5.
	// ------------------------------------------------------------------
	logic signed [WW-1:0] whole_s4;
	logic [AW-1:0]        abs_sum_s4;
	logic [1:0]           edge_s4;
	logic [OW-1:0]        a01, a12, a20;
	logic [1:0]           edge_d;

	assign a01 = o01_s3[OW-1] ? OW'(-o01_s3) : OW'(o01_s3);
	assign a12 = o12_s3[OW-1] ? OW'(-o12_s3) : OW'(o12_s3);
	assign a20 = o20_s3[OW-1] ? OW'(-o20_s3) : OW'(o20_s3);

	// Edge ab tests orient(a,b,p) = O01, bc tests O12, ca tests O20.
	always_comb begin
		if (o01_s3 == '0 && box_s3[0]) begin
			edge_d = tpp_pkg::EDGE_AB;
		end else if (o12_s3 == '0 && box_s3[1]) begin
			edge_d = tpp_pkg::EDGE_BC;
		end else if (o20_s3 == '0 && box_s3[2]) begin
			edge_d = tpp_pkg::EDGE_CA;
		end else begin
			edge_d = tpp_pkg::EDGE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			whole_s4   <= WW'(o01_s3) + WW'(o12_s3) + WW'(o20_s3);
			abs_sum_s4 <= AW'(a01) + AW'(a12) + AW'(a20);
			edge_s4    <= edge_d;
		end
	end

	assign mul_en.s4 = rdy4 && v_s3;
	assign mul_en.s5 = rdy5 && v_s4;

	logic signed [TW-1:0] term0_s5, term1_s5, term2_s5;

	tpp_wide_mul u_term0 (
		.clk     (clk),
		.en      (mul_en),
		.len     (l0_s3),
		.orient  (o12_s3),
		.term_s5 (term0_s5)
	);

	tpp_wide_mul u_term1 (
		.clk     (clk),
		.en      (mul_en),
		.len     (l1_s3),
		.orient  (o20_s3),
		.term_s5 (term1_s5)
	);

	tpp_wide_mul u_term2 (
		.clk     (clk),
		.en      (mul_en),
		.len     (l2_s3),
		.orient  (o01_s3),
		.term_s5 (term2_s5)
	);

	// ------------------------------------------------------------------
	// Stage 5: containment compare and winding of abc.
	// ------------------------------------------------------------------
	logic [WW-1:0] whole_abs;
	logic [1:0]    orient_d;
	logic          inside_s5;
	logic [1:0]    orient_s5;
	logic [1:0]    edge_s5;

	assign whole_abs = whole_s4[WW-1] ? WW'(-whole_s4) : WW'(whole_s4);

	always_comb begin
		if (whole_s4[WW-1]) begin
			orient_d = tpp_pkg::ORIENT_CW;
		end else if (whole_s4 == '0) begin
			orient_d = tpp_pkg::ORIENT_ZERO;
		end else begin
			orient_d = tpp_pkg::ORIENT_CCW;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			inside_s5 <= (whole_abs == WW'(abs_sum_s4));
			orient_s5 <= orient_d;
			edge_s5   <= edge_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: determinant sign, output register. Drop the incircle flag
	// for collinear vertices; flip its sense for clockwise triangles.
	// ------------------------------------------------------------------
	logic signed [DT-1:0] det;
	logic                 det_pos;
	logic                 det_neg;
	logic                 inc_d;
	tpp_pkg::tpp_res_t    res_s6;

	assign det     = DT'(term0_s5) + DT'(term1_s5) + DT'(term2_s5);
	assign det_neg = det[DT-1];
	assign det_pos = !det[DT-1] && (det != '0);

	always_comb begin
		case (orient_s5)
			tpp_pkg::ORIENT_CCW: inc_d = det_pos;
			tpp_pkg::ORIENT_CW:  inc_d = det_neg;
			default:             inc_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			res_s6.inside_res  <= inside_s5;
			res_s6.on_edge     <= (edge_s5 != tpp_pkg::EDGE_NONE);
			res_s6.edge_index  <= edge_s5;
			res_s6.in_circle   <= inc_d;
			res_s6.degenerate  <= (orient_s5 == tpp_pkg::ORIENT_ZERO);
			res_s6.orientation <= orient_s5;
		end
	end

	assign res_data = res_s6;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`TPP_ASSERT_IMPL(a_degen_no_circle, res_valid && res_data.degenerate, !res_data.in_circle && (res_data.orientation == tpp_pkg::ORIENT_ZERO), "degenerate result with circle or winding set")
	`TPP_ASSERT_IMPL(a_edge_flag_match, res_valid, res_data.on_edge == (res_data.edge_index != tpp_pkg::EDGE_NONE), "on_edge disagrees with edge_index")
	`TPP_ASSERT_IMPL(a_edge_implies_inside, res_valid && res_data.on_edge, res_data.inside_res, "point on an edge reported outside")
	`TPP_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, v_s1, "accepted request missing from stage 1")

endmodule

`default_nettype wire

// ----- hdl/tpp_wide_mul.sv -----
// Two-stage split multiplier: squared length times orient value, exact.
// Depends on tpp_pkg for widths and the stage strobe struct.
`default_nettype none

module tpp_wide_mul (
	input  wire logic                                 clk,
	input  wire tpp_pkg::tpp_stage_en_t               en,
	input  wire logic signed [tpp_pkg::LEN_W-1:0]     len,
	input  wire logic signed [tpp_pkg::ORIENT_W-1:0]  orient,
	output logic signed [tpp_pkg::TERM_W-1:0]         term_s5
);

	localparam int K    = tpp_pkg::SPLIT_W;
	localparam int HL_W = tpp_pkg::LEN_W - K;
	localparam int HO_W = tpp_pkg::ORIENT_W - K;

	logic signed [K:0]      len_lo;
	logic signed [K:0]      ori_lo;
	logic signed [HL_W-1:0] len_hi;
	logic signed [HO_W-1:0] ori_hi;

	logic signed [tpp_pkg::PART_W-1:0] pp_ll_s4;
	logic signed [tpp_pkg::PART_W-1:0] pp_lh_s4;
	logic signed [tpp_pkg::PART_W-1:0] pp_hl_s4;
	logic signed [tpp_pkg::PART_W-1:0] pp_hh_s4;

	logic signed [tpp_pkg::TERM_W-1:0] cross_sum;

	// Low slices are unsigned, high slices carry the sign.
	assign len_lo = $signed({1'b0, len[K-1:0]});
	assign ori_lo = $signed({1'b0, orient[K-1:0]});
	assign len_hi = $signed(len[tpp_pkg::LEN_W-1:K]);
	assign ori_hi = $signed(orient[tpp_pkg::ORIENT_W-1:K]);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pp_ll_s4 <= tpp_pkg::PART_W'(len_lo) * tpp_pkg::PART_W'(ori_lo);
			pp_lh_s4 <= tpp_pkg::PART_W'(len_lo) * tpp_pkg::PART_W'(ori_hi);
			pp_hl_s4 <= tpp_pkg::PART_W'(len_hi) * tpp_pkg::PART_W'(ori_lo);
			pp_hh_s4 <= tpp_pkg::PART_W'(len_hi) * tpp_pkg::PART_W'(ori_hi);
		end
	end

	assign cross_sum = tpp_pkg::TERM_W'(pp_lh_s4) + tpp_pkg::TERM_W'(pp_hl_s4);

	// Recombine; wraparound is harmless since the exact product fits TERM_W.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			term_s5 <= tpp_pkg::TERM_W'(pp_ll_s4)
				+ (cross_sum <<< K)
				+ (tpp_pkg::TERM_W'(pp_hh_s4) <<< (2 * K));
		end
	end

endmodule

`default_nettype wire
